/* src/lesp_pkg.sv */
// Shared types and constants for the little-endian stream packer.
`timescale 1ns / 1ps

package lesp_pkg;

  localparam int CW = 11;  // cursor, capacity and bytes_left width

  localparam logic [CW-1:0] CAP_RESET = 11'd1024;
  localparam logic [2:0]    GROUP_MAX_BITS = 3'd5;

  localparam logic [3:0] CMD_REWIND  = 4'd0;
  localparam logic [3:0] CMD_WRITE8  = 4'd1;
  localparam logic [3:0] CMD_WRITE16 = 4'd2;
  localparam logic [3:0] CMD_WRITE32 = 4'd3;
  localparam logic [3:0] CMD_WBIT    = 4'd4;
  localparam logic [3:0] CMD_READ8   = 4'd5;
  localparam logic [3:0] CMD_READ16  = 4'd6;
  localparam logic [3:0] CMD_READ32  = 4'd7;
  localparam logic [3:0] CMD_RBIT    = 4'd8;

  // What a request resolves to once its bounds check is known
  typedef enum logic [2:0] {
    OP_NONE,
    OP_REWIND,
    OP_WR,
    OP_RD,
    OP_WBIT_NEW,
    OP_WBIT_ADD,
    OP_RBIT_NEW,
    OP_RBIT_ADD
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CAPT,
    ST_WRITE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic mem_rd;
    logic capture;
    logic mem_wr;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic clr_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* src/lesp_ctrl.sv */
// Sequencer for clearing, byte reads, byte writes and result hand-off.
`timescale 1ns / 1ps

module lesp_ctrl
  import lesp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (stat.op)
          OP_WR, OP_WBIT_NEW:                    state_nxt = ST_WRITE;
          OP_RD, OP_WBIT_ADD, OP_RBIT_NEW,
          OP_RBIT_ADD:                           state_nxt = ST_READ;
          default:                               state_nxt = ST_FIN;
        endcase
      end
      ST_READ: state_nxt = ST_CAPT;
      ST_CAPT: begin
        if (stat.op == OP_RD && !stat.last) state_nxt = ST_READ;
        else if (stat.op == OP_WBIT_ADD)    state_nxt = ST_WRITE;
        else                                state_nxt = ST_FIN;
      end
      ST_WRITE: begin
        if (!(stat.op == OP_WR && !stat.last)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ: cmd.mem_rd = 1'b1;
      ST_CAPT: begin
        cmd.capture = 1'b1;
        cmd.step    = (stat.op == OP_RD) && !stat.last;
      end
      ST_WRITE: begin
        cmd.mem_wr = 1'b1;
        cmd.step   = (stat.op == OP_WR) && !stat.last;
      end
      ST_FIN: cmd.commit = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* src/lesp_dp.sv */
// Byte store, cursor and bit-group state, and the result register.
`timescale 1ns / 1ps

module lesp_dp
  import lesp_pkg::*;
#(
  parameter int STORE_BYTES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctrl_cmd_t     cmd,
  output ctrl_stat_t    stat,
  input  logic [3:0]    in_cmd,
  input  logic [31:0]   in_write_value,
  input  logic          cfg_valid,
  input  logic [CW-1:0] cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_ok,
  output logic [31:0]   out_read_value,
  output logic [CW-1:0] out_bytes_left
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CAP_LIM = (STORE_BYTES > 2047) ? 2047 : STORE_BYTES;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_r;

  logic [AW-1:0] clr_cnt_r;
  logic [CW-1:0] cap_r;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [AW-1:0] gpos_r, gpos_nxt;
  logic [2:0]    gbits_r, gbits_nxt;
  logic [3:0]    cmd_r;
  logic [31:0]   wv_r;
  logic [31:0]   acc_r;
  logic [1:0]    k_r;

  logic          out_valid_r;
  logic          ok_r;
  logic [31:0]   rv_r;
  logic [CW-1:0] left_r;

  logic [CW-1:0] eff_cap;
  logic [2:0]    nbytes;
  logic          fit;
  op_t           op;
  logic [AW-1:0] addr;
  logic [7:0]    wdata;
  logic [7:0]    byte_q;
  logic [4:0]    bit_set;
  logic [2:0]    bidx;
  logic          ok_nxt;
  logic [31:0]   rv_nxt;

  assign eff_cap = (cap_r > CW'(CAP_LIM)) ? CW'(CAP_LIM) : cap_r;

  always_comb begin
    case (cmd_r)
      CMD_WRITE16, CMD_READ16: nbytes = 3'd2;
      CMD_WRITE32, CMD_READ32: nbytes = 3'd4;
      default:                 nbytes = 3'd1;
    endcase
  end

  assign fit = ({1'b0, cursor_r} + {{(CW-2){1'b0}}, nbytes}) <= {1'b0, eff_cap};

  always_comb begin
    case (cmd_r)
      CMD_REWIND: op = OP_REWIND;
      CMD_WRITE8, CMD_WRITE16, CMD_WRITE32: op = fit ? OP_WR : OP_NONE;
      CMD_READ8, CMD_READ16, CMD_READ32:    op = fit ? OP_RD : OP_NONE;
      CMD_WBIT: begin
        if (gbits_r == 3'd0 || gbits_r >= GROUP_MAX_BITS) op = fit ? OP_WBIT_NEW : OP_NONE;
        else                                              op = OP_WBIT_ADD;
      end
      CMD_RBIT: begin
        if (gbits_r == 3'd0) op = fit ? OP_RBIT_NEW : OP_NONE;
        else                 op = OP_RBIT_ADD;
      end
      default: op = OP_NONE;
    endcase
  end

  // Continuing a group works on its recorded byte, everything else at the cursor
  assign addr = ((op == OP_WBIT_ADD || op == OP_RBIT_ADD) ? gpos_r : AW'(cursor_r))
              + AW'(k_r);

  assign byte_q  = acc_r[7:0];
  assign bit_set = byte_q[4:0] | (5'(wv_r[0]) << gbits_r);

  always_comb begin
    case (op)
      OP_WR:       wdata = wv_r[8*k_r +: 8];
      OP_WBIT_ADD: wdata = {gbits_r, bit_set};
      default:     wdata = {7'd0, wv_r[0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= 8'd0;
    end else if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign bidx = byte_q[7:5] + 3'd1 - gbits_r;

  always_comb begin
    cursor_nxt = cursor_r;
    gpos_nxt   = gpos_r;
    gbits_nxt  = gbits_r;
    ok_nxt     = 1'b1;
    rv_nxt     = '0;
    case (op)
      OP_REWIND: begin
        cursor_nxt = '0;
        gpos_nxt   = '0;
        gbits_nxt  = '0;
      end
      OP_WR: begin
        cursor_nxt = cursor_r + CW'(nbytes);
        gbits_nxt  = '0;
      end
      OP_RD: begin
        cursor_nxt = cursor_r + CW'(nbytes);
        rv_nxt     = acc_r;
      end
      OP_WBIT_NEW: begin
        gpos_nxt   = AW'(cursor_r);
        cursor_nxt = cursor_r + CW'(1);
        gbits_nxt  = 3'd1;
      end
      OP_WBIT_ADD: gbits_nxt = gbits_r + 3'd1;
      OP_RBIT_NEW: begin
        gpos_nxt   = AW'(cursor_r);
        cursor_nxt = cursor_r + CW'(1);
        gbits_nxt  = byte_q[7:5];
        rv_nxt     = {31'd0, byte_q[0]};
      end
      OP_RBIT_ADD: begin
        gbits_nxt = gbits_r - 3'd1;
        rv_nxt    = {31'd0, byte_q[bidx]};
      end
      default: ok_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      cap_r       <= CAP_RESET;
      cursor_r    <= '0;
      gpos_r      <= '0;
      gbits_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cfg_valid)  cap_r     <= cfg_data;
      if (cmd.accept) k_r <= '0;
      else if (cmd.step) k_r <= k_r + 2'd1;
      if (cmd.commit) begin
        cursor_r <= cursor_nxt;
        gpos_r   <= gpos_nxt;
        gbits_r  <= gbits_nxt;
      end
      if (cmd.commit)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_cmd;
      wv_r  <= in_write_value;
      acc_r <= '0;
    end else if (cmd.capture) begin
      acc_r[8*k_r +: 8] <= rdata_r;
    end
    if (cmd.commit) begin
      ok_r   <= ok_nxt;
      rv_r   <= rv_nxt;
      left_r <= (cursor_nxt < eff_cap) ? (eff_cap - cursor_nxt) : '0;
    end
  end

  assign stat.op       = op;
  assign stat.last     = ({1'b0, k_r} == nbytes - 3'd1);
  assign stat.clr_last = (clr_cnt_r == AW'(STORE_BYTES - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_ok         = ok_r;
  assign out_read_value = rv_r;
  assign out_bytes_left = left_r;

endmodule

/* src/le_stream_pack_with_bit_groups.sv */
// Top level of the little-endian stream packer with packed bit groups.
//
// Requests arrive on in_valid/in_ready with in_cmd and in_write_value; one
// result per request leaves on out_valid/out_ready with out_ok,
// out_read_value and out_bytes_left. cfg_valid/cfg_ready writes the usable
// capacity (cfg_ready is always high); write it only while no request is open.
//
// One request is worked on at a time over a single-port byte memory with a
// registered read. After acceptance the request is resolved; then:
//   rewind, unknown or failed request: straight to the result
//   write of n bytes (n = 1, 2, 4), or a bit opening a group: byte writes
//   read or bit read: read, capture; bit added to a group: read, capture, write
// in_ready rises again at the same clock edge that loads the result.
// The result register frees the input side: the next request is taken while
// a result still waits; if out_ready stays low, that request holds in
// its last step until the register empties.
// After reset a clearing pass zeroes the store, one byte a cycle, through
// all STORE_BYTES bytes; in_ready stays low until it ends.
`timescale 1ns / 1ps

module le_stream_pack_with_bit_groups
  import lesp_pkg::*;
#(
  parameter int STORE_BYTES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [3:0]    in_cmd,
  input  logic [31:0]   in_write_value,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [CW-1:0] cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_ok,
  output logic [31:0]   out_read_value,
  output logic [CW-1:0] out_bytes_left
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  lesp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lesp_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_write_value (in_write_value),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_bytes_left (out_bytes_left)
  );

endmodule
